FILE: rtl/mutex_lock_manager_top_defines.svh
// Assertion macros shared by the checker of the mutex lock manager.
`ifndef MUTEX_LOCK_MANAGER_TOP_DEFINES_SVH
`define MUTEX_LOCK_MANAGER_TOP_DEFINES_SVH
// Property that holds on every clock edge outside reset.
`define MLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property that must hold during reset too.
`define MLM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

FILE: rtl/mlm_pkg.sv
// Package with the opcodes, status codes and shared types of the mutex lock manager.
package mlm_pkg;
   localparam logic [1:0] OP_OPEN = 2'd0;
   localparam logic [1:0] OP_ACQUIRE = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_RELEASE_ALL = 2'd3;

   localparam logic [3:0] ST_FOUND = 4'd0;
   localparam logic [3:0] ST_CREATED = 4'd1;
   localparam logic [3:0] ST_FULL = 4'd2;
   localparam logic [3:0] ST_GRANTED = 4'd3;
   localparam logic [3:0] ST_QUEUED = 4'd4;
   localparam logic [3:0] ST_HANDOFF = 4'd5;
   localparam logic [3:0] ST_UNLOCKED = 4'd6;
   localparam logic [3:0] ST_NOTOWNER = 4'd7;
   localparam logic [3:0] ST_NONE = 4'd8;

   localparam int MAX_RESULTS = 16;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] lock_key;
      logic [3:0]  lock_index;
      logic [5:0]  task_id;
   } cmd_type;

   typedef struct packed {
      logic [3:0] status;
      logic [3:0] slot;
      logic [5:0] woken_task;
      logic       woke;
      logic       last;
   } rsp_type;
endpackage

FILE: rtl/mlm_cmd_queue.sv
// Short command queue between the request front and the lock engine.
module mlm_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mlm_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output mlm_pkg::cmd_type pop_data,
   output logic             empty
);
   mlm_pkg::cmd_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff ^ do_push;
      rd_in = rd_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

FILE: rtl/mlm_engine.sv
// Lock engine: holds the mutex table and carries out one command at a time.
module mlm_engine #(
   parameter int LOCK_COUNT = 16,
   parameter int TASK_COUNT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  mlm_pkg::cmd_type cmd,
   output logic             cmd_take,
   output logic             rsp_valid,
   output mlm_pkg::rsp_type rsp,
   input  logic             rsp_take
);
   localparam int SW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
   localparam int TW = $clog2(TASK_COUNT);
   localparam int CW = $clog2(LOCK_COUNT + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_NEXT = 3'd4;

   logic [31:0] key_ff [LOCK_COUNT];
   logic [LOCK_COUNT-1:0] used_ff, locked_ff, nonempty_ff;
   logic [5:0] owner_ff [LOCK_COUNT];
   logic [5:0] head_ff [LOCK_COUNT];
   logic [5:0] tail_ff [LOCK_COUNT];
   logic [5:0] next_mem [TASK_COUNT];
   logic [5:0] next_rd_ff;

   logic [2:0] state_ff, state_in;
   mlm_pkg::cmd_type cmd_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0] n_ff, n_in;
   logic found_ff, found_in, free_ff, free_in;
   logic [SW-1:0] fslot_ff, fslot_in, freeslot_ff, freeslot_in;
   mlm_pkg::rsp_type out_ff, out_in;
   mlm_pkg::rsp_type hold_ff, hold_in;
   logic out_valid_ff, out_valid_in;

   logic [SW-1:0] cur;
   logic [SW-1:0] cs;
   logic in_range, task_ok, hit;
   logic [TW-1:0] cmd_task, tail_task, head_task, rd_task;

   assign cur = idx_ff[SW-1:0];
   assign cs = cmd_ff.lock_index[SW-1:0];
   assign in_range = {28'd0, cmd_ff.lock_index} < 32'(LOCK_COUNT);
   assign task_ok = {26'd0, cmd_ff.task_id} < 32'(TASK_COUNT);
   assign cmd_task = cmd_ff.task_id[TW-1:0];
   assign tail_task = tail_ff[cs][TW-1:0];
   assign head_task = head_ff[cur][TW-1:0];
   assign rd_task = (state_ff == S_IDLE) ? head_ff[cmd.lock_index[SW-1:0]][TW-1:0]
      : (cmd_ff.op == mlm_pkg::OP_RELEASE) ? head_ff[cs][TW-1:0] : head_task;
   assign hit = locked_ff[cur] && owner_ff[cur] == cmd_ff.task_id;
   assign cmd_take = state_ff == S_IDLE && cmd_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp = out_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      n_in = n_ff;
      found_in = found_ff;
      free_in = free_ff;
      fslot_in = fslot_ff;
      freeslot_in = freeslot_ff;
      out_in = out_ff;
      hold_in = hold_ff;
      out_valid_in = out_valid_ff && !rsp_take;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               idx_in = '0;
               n_in = '0;
               found_in = 1'b0;
               free_in = 1'b0;
               state_in = (cmd.op == mlm_pkg::OP_OPEN || cmd.op == mlm_pkg::OP_RELEASE_ALL)
                  ? S_SCAN : S_EXEC;
            end
         end
         S_SCAN: begin
            if (cmd_ff.op == mlm_pkg::OP_OPEN) begin
               if (!found_ff && used_ff[cur] && key_ff[cur] == cmd_ff.lock_key) begin
                  found_in = 1'b1;
                  fslot_in = cur;
               end
               if (!free_ff && !used_ff[cur]) begin
                  free_in = 1'b1;
                  freeslot_in = cur;
               end
               if (idx_ff == CW'(LOCK_COUNT - 1)) begin
                  state_in = S_EXEC;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (idx_ff == CW'(LOCK_COUNT) || n_ff == 5'(mlm_pkg::MAX_RESULTS)) begin
                  state_in = S_EXEC;
               end else if (hit) begin
                  state_in = S_EXEC;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_EXEC: begin
            if (!out_valid_ff || rsp_take) begin
               out_valid_in = 1'b1;
               out_in = '0;
               out_in.last = 1'b1;
               out_in.slot = cmd_ff.lock_index;
               state_in = S_WAIT;
               case (cmd_ff.op)
                  mlm_pkg::OP_OPEN: begin
                     if (found_ff) begin
                        out_in.status = mlm_pkg::ST_FOUND;
                        out_in.slot = 4'(fslot_ff);
                     end else if (free_ff) begin
                        out_in.status = mlm_pkg::ST_CREATED;
                        out_in.slot = 4'(freeslot_ff);
                     end else begin
                        out_in.status = mlm_pkg::ST_FULL;
                        out_in.slot = '0;
                     end
                  end
                  mlm_pkg::OP_ACQUIRE: begin
                     if (!in_range || !task_ok) begin
                        out_in.status = mlm_pkg::ST_NOTOWNER;
                     end else if (!locked_ff[cs]) begin
                        out_in.status = mlm_pkg::ST_GRANTED;
                     end else begin
                        out_in.status = mlm_pkg::ST_QUEUED;
                     end
                  end
                  mlm_pkg::OP_RELEASE: begin
                     if (!in_range || !locked_ff[cs] || owner_ff[cs] != cmd_ff.task_id) begin
                        out_in.status = mlm_pkg::ST_NOTOWNER;
                     end else if (nonempty_ff[cs]) begin
                        out_in.status = mlm_pkg::ST_HANDOFF;
                        out_in.woken_task = head_ff[cs];
                        out_in.woke = 1'b1;
                     end else begin
                        out_in.status = mlm_pkg::ST_UNLOCKED;
                     end
                  end
                  default: begin
                     if (idx_ff == CW'(LOCK_COUNT) || n_ff == 5'(mlm_pkg::MAX_RESULTS)) begin
                        if (n_ff == '0) begin
                           out_in.status = mlm_pkg::ST_NONE;
                           out_in.slot = '0;
                        end else begin
                           out_in = hold_ff;
                           out_in.last = 1'b1;
                        end
                        state_in = S_WAIT;
                     end else begin
                        hold_in = '0;
                        hold_in.slot = 4'(cur);
                        if (nonempty_ff[cur]) begin
                           hold_in.status = mlm_pkg::ST_HANDOFF;
                           hold_in.woken_task = head_ff[cur];
                           hold_in.woke = 1'b1;
                        end else begin
                           hold_in.status = mlm_pkg::ST_UNLOCKED;
                        end
                        if (n_ff == '0) begin
                           out_valid_in = out_valid_ff && !rsp_take;
                        end else begin
                           out_in = hold_ff;
                        end
                        n_in = n_ff + 1'b1;
                        idx_in = idx_ff + 1'b1;
                        state_in = S_NEXT;
                     end
                  end
               endcase
            end
         end
         S_NEXT: begin
            state_in = S_SCAN;
         end
         S_WAIT: begin
            if (!out_valid_ff || rsp_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         locked_ff <= '0;
         nonempty_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == S_EXEC && (!out_valid_ff || rsp_take)) begin
            unique case (cmd_ff.op)
               mlm_pkg::OP_OPEN: begin
                  if (!found_ff && free_ff) begin
                     used_ff[freeslot_ff] <= 1'b1;
                     key_ff[freeslot_ff] <= cmd_ff.lock_key;
                  end
               end
               mlm_pkg::OP_ACQUIRE: begin
                  if (in_range && task_ok) begin
                     if (!locked_ff[cs]) begin
                        locked_ff[cs] <= 1'b1;
                        owner_ff[cs] <= cmd_ff.task_id;
                     end else begin
                        if (nonempty_ff[cs]) begin
                           next_mem[tail_task] <= cmd_ff.task_id;
                        end else begin
                           head_ff[cs] <= cmd_ff.task_id;
                           nonempty_ff[cs] <= 1'b1;
                        end
                        tail_ff[cs] <= cmd_ff.task_id;
                     end
                  end
               end
               mlm_pkg::OP_RELEASE: begin
                  if (in_range && locked_ff[cs] && owner_ff[cs] == cmd_ff.task_id) begin
                     if (nonempty_ff[cs]) begin
                        owner_ff[cs] <= head_ff[cs];
                        if (head_ff[cs] == tail_ff[cs]) begin
                           nonempty_ff[cs] <= 1'b0;
                        end else begin
                           head_ff[cs] <= next_rd_ff;
                        end
                     end else begin
                        locked_ff[cs] <= 1'b0;
                     end
                  end
               end
               default: begin
                  if (state_in == S_NEXT) begin
                     if (nonempty_ff[cur]) begin
                        owner_ff[cur] <= head_ff[cur];
                        if (head_ff[cur] == tail_ff[cur]) begin
                           nonempty_ff[cur] <= 1'b0;
                        end else begin
                           head_ff[cur] <= next_rd_ff;
                        end
                     end else begin
                        locked_ff[cur] <= 1'b0;
                     end
                  end
               end
            endcase
         end
      end
      if (state_ff == S_IDLE && cmd_valid) begin
         cmd_ff <= cmd;
      end
      idx_ff <= idx_in;
      n_ff <= n_in;
      found_ff <= found_in;
      free_ff <= free_in;
      fslot_ff <= fslot_in;
      freeslot_ff <= freeslot_in;
      out_ff <= out_in;
      hold_ff <= hold_in;
      next_rd_ff <= next_mem[rd_task];
   end
endmodule

FILE: rtl/mlm_rsp_queue.sv
// Result queue that holds result beats until the consumer pops them.
module mlm_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mlm_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output mlm_pkg::rsp_type pop_data,
   output logic             empty
);
   mlm_pkg::rsp_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_ff ^ do_push;
         rd_ff <= rd_ff ^ do_pop;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

FILE: rtl/mutex_lock_manager_top.sv
// Top level of the mutex lock manager: command queue, lock engine and result queue.
// Requests enter a two-beat command queue and are carried out one at a time by the lock
// engine. Open walks the whole lock table, one slot a cycle. Release-all walks the table
// too. Results wait in a two-beat result queue; the last beat of each request carries last.
module mutex_lock_manager_top #(
   parameter int LOCK_COUNT = 16,
   parameter int TASK_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_lock_key,
   input  logic [3:0]  req_lock_index,
   input  logic [5:0]  req_task_id,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [5:0]  rsp_woken_task,
   output logic        rsp_woke,
   output logic        rsp_last
);
   mlm_pkg::cmd_type in_cmd, q_cmd;
   mlm_pkg::rsp_type e_rsp, o_rsp;
   logic q_empty, take, e_valid, r_full;

   assign in_cmd = '{op: req_op, lock_key: req_lock_key, lock_index: req_lock_index,
      task_id: req_task_id};

   mlm_cmd_queue u_cmd (
      .clock, .reset, .push, .push_data(in_cmd), .full,
      .pop(take), .pop_data(q_cmd), .empty(q_empty)
   );

   mlm_engine #(.LOCK_COUNT(LOCK_COUNT), .TASK_COUNT(TASK_COUNT)) u_engine (
      .clock, .reset, .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(take),
      .rsp_valid(e_valid), .rsp(e_rsp), .rsp_take(!r_full && e_valid)
   );

   mlm_rsp_queue u_rsp (
      .clock, .reset, .push(e_valid), .push_data(e_rsp), .full(r_full),
      .pop, .pop_data(o_rsp), .empty
   );

   assign rsp_status = o_rsp.status;
   assign rsp_slot = o_rsp.slot;
   assign rsp_woken_task = o_rsp.woken_task;
   assign rsp_woke = o_rsp.woke;
   assign rsp_last = o_rsp.last;
endmodule

FILE: rtl/mlm_checker.sv
// Port checker of the mutex lock manager, bound to the top level.
`include "mutex_lock_manager_top_defines.svh"
module mlm_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic [3:0] rsp_status,
   input logic       rsp_woke,
   input logic [5:0] rsp_woken_task
);
   `MLM_ASSERT(woke_only_handoff, !empty |-> (rsp_woke == (rsp_status == mlm_pkg::ST_HANDOFF)), "woke outside handoff")
   `MLM_ASSERT(woken_zero, (!empty && !rsp_woke) |-> rsp_woken_task == 6'd0, "stray woken task")
   `MLM_ASSERT(status_range, !empty |-> rsp_status <= mlm_pkg::ST_NONE, "bad status")
   `MLM_ASSERT_ALWAYS(reset_clears, $past(reset) |-> (empty && !full), "queues not empty after reset")
endmodule

bind mutex_lock_manager_top mlm_checker u_mlm_checker (
   .clock, .reset, .full, .empty, .rsp_status, .rsp_woke, .rsp_woken_task
);

FILE: tb/tb_mutex_lock_manager_top.sv
// Self-checking testbench of the mutex lock manager: directed table, then random requests.
module tb_mutex_lock_manager_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOCKS = 16;
   localparam int TOTAL = 420;
   localparam int QUIET = 60;

   typedef struct {
      logic [1:0]       op;
      logic [31:0]      key;
      logic [3:0]       idx;
      logic [5:0]       tid;
      bit               typed;
      mlm_pkg::rsp_type rsp;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_op;
   logic [31:0] req_lock_key;
   logic [3:0]  req_lock_index;
   logic [5:0]  req_task_id;
   logic        empty;
   logic        pop;
   logic [3:0]  rsp_status;
   logic [3:0]  rsp_slot;
   logic [5:0]  rsp_woken_task;
   logic        rsp_woke;
   logic        rsp_last;

   logic [31:0] lock_key_mem [LOCKS];
   bit          lock_used [LOCKS];
   bit          lock_held [LOCKS];
   logic [5:0]  lock_owner [LOCKS];
   logic [5:0]  queue_head [LOCKS];
   logic [5:0]  queue_tail [LOCKS];
   bit          queue_busy [LOCKS];
   logic [5:0]  waiter_link [64];

   mlm_pkg::rsp_type expected_rsps [$];
   table_row_type    directed [20];
   logic [31:0]      key_pool [24];
   int               fails;
   int               cycles;
   int               sent;
   bit               long_hold;

   mutex_lock_manager_top u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_op(req_op), .req_lock_key(req_lock_key), .req_lock_index(req_lock_index),
      .req_task_id(req_task_id), .empty(empty), .pop(pop), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_woken_task(rsp_woken_task), .rsp_woke(rsp_woke),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("mutex_lock_manager_top test failed");
         $finish;
      end
   end

   task automatic surrender_lock(input int s, input bit last);
      logic [5:0] h;
      if (queue_busy[s]) begin
         h = queue_head[s];
         lock_owner[s] = h;
         if (h == queue_tail[s]) queue_busy[s] = 1'b0;
         else queue_head[s] = waiter_link[h];
         expected_rsps.push_back(mlm_pkg::rsp_type'{mlm_pkg::ST_HANDOFF, 4'(s), h, 1'b1, last});
      end else begin
         lock_held[s] = 1'b0;
         expected_rsps.push_back(
            mlm_pkg::rsp_type'{mlm_pkg::ST_UNLOCKED, 4'(s), 6'd0, 1'b0, last});
      end
   endtask

   task automatic lock_table_step(input logic [1:0] op, input logic [31:0] key,
                                  input logic [3:0] idx, input logic [5:0] tid);
      int n;
      n = 0;
      case (op)
         mlm_pkg::OP_OPEN: begin
            for (int i = 0; i < LOCKS; i++)
               if (n == 0 && lock_used[i] && lock_key_mem[i] == key) begin
                  expected_rsps.push_back(
                     mlm_pkg::rsp_type'{mlm_pkg::ST_FOUND, 4'(i), 6'd0, 1'b0, 1'b1});
                  n = 1;
               end
            for (int i = 0; i < LOCKS; i++)
               if (n == 0 && !lock_used[i]) begin
                  lock_used[i] = 1'b1;
                  lock_key_mem[i] = key;
                  expected_rsps.push_back(
                     mlm_pkg::rsp_type'{mlm_pkg::ST_CREATED, 4'(i), 6'd0, 1'b0, 1'b1});
                  n = 1;
               end
            if (n == 0) expected_rsps.push_back(
               mlm_pkg::rsp_type'{mlm_pkg::ST_FULL, 4'd0, 6'd0, 1'b0, 1'b1});
         end
         mlm_pkg::OP_ACQUIRE: begin
            if (!lock_held[idx]) begin
               lock_held[idx] = 1'b1;
               lock_owner[idx] = tid;
               expected_rsps.push_back(
                  mlm_pkg::rsp_type'{mlm_pkg::ST_GRANTED, idx, 6'd0, 1'b0, 1'b1});
            end else begin
               if (queue_busy[idx]) waiter_link[queue_tail[idx]] = tid;
               else begin
                  queue_head[idx] = tid;
                  queue_busy[idx] = 1'b1;
               end
               queue_tail[idx] = tid;
               expected_rsps.push_back(
                  mlm_pkg::rsp_type'{mlm_pkg::ST_QUEUED, idx, 6'd0, 1'b0, 1'b1});
            end
         end
         mlm_pkg::OP_RELEASE: begin
            if (!lock_held[idx] || lock_owner[idx] != tid)
               expected_rsps.push_back(
                  mlm_pkg::rsp_type'{mlm_pkg::ST_NOTOWNER, idx, 6'd0, 1'b0, 1'b1});
            else surrender_lock(idx, 1'b1);
         end
         default: begin
            for (int i = 0; i < LOCKS; i++)
               if (n < mlm_pkg::MAX_RESULTS && lock_held[i] && lock_owner[i] == tid) begin
                  surrender_lock(i, 1'b0);
                  n++;
               end
            if (n == 0) expected_rsps.push_back(
               mlm_pkg::rsp_type'{mlm_pkg::ST_NONE, 4'd0, 6'd0, 1'b0, 1'b1});
            else expected_rsps[$].last = 1'b1;
         end
      endcase
   endtask

   initial begin
      mlm_pkg::rsp_type no_rsp;
      no_rsp = '0;
      directed[0]  = '{mlm_pkg::OP_OPEN, 32'h0, 4'd0, 6'd0, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_CREATED, 4'd0, 6'd0, 1'b0, 1'b1}};
      directed[1]  = '{mlm_pkg::OP_OPEN, 32'hFFFFFFFF, 4'd15, 6'd63, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_CREATED, 4'd1, 6'd0, 1'b0, 1'b1}};
      directed[2]  = '{mlm_pkg::OP_OPEN, 32'h0, 4'd0, 6'd0, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_FOUND, 4'd0, 6'd0, 1'b0, 1'b1}};
      directed[3]  = '{mlm_pkg::OP_OPEN, 32'hFFFFFFFF, 4'd0, 6'd0, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_FOUND, 4'd1, 6'd0, 1'b0, 1'b1}};
      directed[4]  = '{mlm_pkg::OP_ACQUIRE, 32'h0, 4'd0, 6'd5, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_GRANTED, 4'd0, 6'd0, 1'b0, 1'b1}};
      directed[5]  = '{mlm_pkg::OP_ACQUIRE, 32'h0, 4'd0, 6'd63, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_QUEUED, 4'd0, 6'd0, 1'b0, 1'b1}};
      directed[6]  = '{mlm_pkg::OP_ACQUIRE, 32'h0, 4'd0, 6'd5, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_QUEUED, 4'd0, 6'd0, 1'b0, 1'b1}};
      directed[7]  = '{mlm_pkg::OP_RELEASE, 32'h0, 4'd0, 6'd7, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_NOTOWNER, 4'd0, 6'd0, 1'b0, 1'b1}};
      directed[8]  = '{mlm_pkg::OP_RELEASE, 32'h0, 4'd15, 6'd0, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_NOTOWNER, 4'd15, 6'd0, 1'b0, 1'b1}};
      directed[9]  = '{mlm_pkg::OP_RELEASE, 32'h0, 4'd0, 6'd5, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_HANDOFF, 4'd0, 6'd63, 1'b1, 1'b1}};
      directed[10] = '{mlm_pkg::OP_RELEASE_ALL, 32'h0, 4'd0, 6'd63, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_HANDOFF, 4'd0, 6'd5, 1'b1, 1'b1}};
      directed[11] = '{mlm_pkg::OP_RELEASE_ALL, 32'h0, 4'd0, 6'd9, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_NONE, 4'd0, 6'd0, 1'b0, 1'b1}};
      directed[12] = '{mlm_pkg::OP_ACQUIRE, 32'h0, 4'd15, 6'd0, 1,
                       mlm_pkg::rsp_type'{mlm_pkg::ST_GRANTED, 4'd15, 6'd0, 1'b0, 1'b1}};
      directed[13] = '{mlm_pkg::OP_ACQUIRE, 32'h0, 4'd3, 6'd0, 0, no_rsp};
      directed[14] = '{mlm_pkg::OP_ACQUIRE, 32'h0, 4'd3, 6'd42, 0, no_rsp};
      directed[15] = '{mlm_pkg::OP_RELEASE_ALL, 32'h0, 4'd0, 6'd0, 0, no_rsp};
      directed[16] = '{mlm_pkg::OP_RELEASE, 32'h0, 4'd3, 6'd42, 0, no_rsp};
      directed[17] = '{mlm_pkg::OP_RELEASE, 32'h0, 4'd3, 6'd42, 0, no_rsp};
      directed[18] = '{mlm_pkg::OP_OPEN, 32'h5A5A5A5A, 4'd0, 6'd0, 0, no_rsp};
      directed[19] = '{mlm_pkg::OP_RELEASE_ALL, 32'h0, 4'd0, 6'd5, 0, no_rsp};
      foreach (key_pool[i]) key_pool[i] = $urandom;
   end

   // Sender: one beat per request, with random gaps and one pause until the block drains.
   initial begin
      logic [1:0]  op;
      logic [31:0] key;
      logic [3:0]  idx;
      logic [5:0]  tid;
      int          pick;
      push = 1'b0;
      req_op = '0;
      req_lock_key = '0;
      req_lock_index = '0;
      req_task_id = '0;
      fails = 0;
      cycles = 0;
      sent = 0;
      long_hold = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int n = 0; n < TOTAL; n++) begin
         if (n < 20) begin
            op = directed[n].op;
            key = directed[n].key;
            idx = directed[n].idx;
            tid = directed[n].tid;
         end else begin
            pick = $urandom_range(0, 99);
            key = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
            idx = 4'($urandom_range(0, 15));
            tid = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 7));
            if (pick < 15) op = mlm_pkg::OP_OPEN;
            else if (pick < 55) op = mlm_pkg::OP_ACQUIRE;
            else if (pick < 90) begin
               op = mlm_pkg::OP_RELEASE;
               if (lock_held[idx] && $urandom_range(0, 4) != 0) tid = lock_owner[idx];
            end else op = mlm_pkg::OP_RELEASE_ALL;
         end
         if (n == 260) begin
            push <= 1'b0;
            while (expected_rsps.size() != 0) @(posedge clock);
            repeat (40) @(posedge clock);
         end else if (n < TOTAL - QUIET && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         push <= 1'b1;
         req_op <= op;
         req_lock_key <= key;
         req_lock_index <= idx;
         req_task_id <= tid;
         @(posedge clock);
         while (full) @(posedge clock);
         lock_table_step(op, key, idx, tid);
         if (n < 20 && directed[n].typed) expected_rsps[$] = directed[n].rsp;
         sent = n + 1;
         if (n == 150) long_hold = 1'b1;
      end
      push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fails == 0) $display("mutex_lock_manager_top test passed");
      else $display("mutex_lock_manager_top test failed");
      $finish;
   end

   // Receiver: random stalls, one long hold-off, and none near the end.
   initial begin
      pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            pop <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (sent < TOTAL - QUIET && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      mlm_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result beat: status %0d slot %0d", rsp_status, rsp_slot);
            fails++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               fails++;
            end
            if (rsp_slot !== want.slot) begin
               $error("slot expected %0d actual %0d", want.slot, rsp_slot);
               fails++;
            end
            if (rsp_woken_task !== want.woken_task) begin
               $error("woken_task expected %0d actual %0d", want.woken_task, rsp_woken_task);
               fails++;
            end
            if (rsp_woke !== want.woke) begin
               $error("woke expected %0d actual %0d", want.woke, rsp_woke);
               fails++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_last);
               fails++;
            end
         end
      end
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/mlm_pkg.sv
rtl/mlm_cmd_queue.sv
rtl/mlm_engine.sv
rtl/mlm_rsp_queue.sv
rtl/mutex_lock_manager_top.sv
rtl/mlm_checker.sv
tb/tb_mutex_lock_manager_top.sv
